// ===== rtl/core/ddm_pkg.sv =====
// Package for the differential drive mixer: payload structs, configuration
// and state records, mode and register index codes, and fixed thresholds.
// No dependencies; every other file of the block imports it.
package ddm_pkg;

   // Mode switch thresholds in mode channel counts.
   localparam logic [15:0] MANUAL_BELOW = 16'd5000;
   localparam logic [15:0] ASSIST_ABOVE = 16'd5500;
   localparam logic [15:0] ASSIST_BELOW = 16'd6500;
   localparam logic [15:0] AUTO_ABOVE   = 16'd7000;

   // Configuration reset values.
   localparam logic [15:0] STEER_CENTER_RST      = 16'd6000;
   localparam logic [15:0] THROTTLE_CENTER_RST   = 16'd6000;
   localparam logic [15:0] REVERSE_THRESHOLD_RST = 16'd900;
   localparam logic [13:0] MOTOR_LIMIT_RST       = 14'h07E0;
   localparam logic [15:0] RAMP_HOLD_END_RST     = 16'd4000;
   localparam logic [15:0] RAMP_RISE_END_RST     = 16'd2000;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      MODE_MANUAL   = 2'd0,
      MODE_ASSISTED = 2'd1,
      MODE_AUTO     = 2'd2
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEER_CENTER      = 3'd0,
      CSR_THROTTLE_CENTER   = 3'd1,
      CSR_REVERSE_THRESHOLD = 3'd2,
      CSR_MOTOR_LIMIT       = 3'd3,
      CSR_RAMP_HOLD_END     = 3'd4,
      CSR_RAMP_RISE_END     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [15:0] steer_channel;
      logic [15:0] throttle_channel;
      logic [15:0] mode_channel;
      logic [15:0] reverse_sensor;
      logic        ms_tick;
   } req_type;

   typedef struct packed {
      logic [13:0] left_drive;
      logic [13:0] right_drive;
      logic [1:0]  drive_mode;
      logic        reverse_active;
   } rsp_type;

   typedef struct packed {
      logic [15:0] steer_center;
      logic [15:0] throttle_center;
      logic [15:0] reverse_threshold;
      logic [13:0] motor_limit;
      logic [15:0] ramp_hold_end;
      logic [15:0] ramp_rise_end;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] ramp_timer;
      logic        ramp_started;
      logic [15:0] ramp_value;
   } state_type;

endpackage

// ===== rtl/core/ddm_core.sv =====
// Combinational mixing datapath: mode decode, autonomous ramp, reverse
// mirroring and left/right drive mixing with saturation.
// Depends on ddm_pkg.
module ddm_core
   import ddm_pkg::*;
(
   input  req_type   item,
   input  state_type cur,
   input  cfg_type   cfg,
   output state_type nxt,
   output rsp_type   result
);

   logic [15:0] timer_adv;
   logic [15:0] timer_eff;
   mode_type    mode_new;
   logic        rev;
   logic [15:0] ramp_new;
   logic [15:0] sv;
   logic [15:0] thr_sel;
   logic [15:0] thr;
   logic [15:0] half;
   logic [15:0] sum_plus;
   logic [15:0] sum_minus;
   logic [13:0] left_raw;
   logic [13:0] right_raw;
   logic        steer_high;

   // Timer advances by the tick first, then mode and reverse flag update.
   always_comb begin
      timer_adv = cur.ramp_timer + {15'd0, item.ms_tick};
      rev       = item.reverse_sensor > cfg.reverse_threshold;
      mode_new  = cur.mode;
      if (item.mode_channel < MANUAL_BELOW) begin
         mode_new = MODE_MANUAL;
      end else if (item.mode_channel > ASSIST_ABOVE && item.mode_channel < ASSIST_BELOW) begin
         mode_new = MODE_ASSISTED;
      end else if (item.mode_channel > AUTO_ABOVE) begin
         mode_new = MODE_AUTO;
      end
   end

   // Autonomous ramp: zero the timer on first entry, then rise, hold, fall.
   always_comb begin
      timer_eff = (mode_new == MODE_AUTO && !cur.ramp_started) ? 16'd0 : timer_adv;
      ramp_new  = cur.ramp_value;
      if (timer_eff >= cfg.ramp_hold_end) begin
         if (cur.ramp_value <= cfg.throttle_center) begin
            ramp_new = cfg.throttle_center;
         end else begin
            ramp_new = {cfg.throttle_center[14:0], 1'b0} - timer_eff;
         end
      end else if (timer_eff <= cfg.ramp_rise_end) begin
         ramp_new = cfg.throttle_center + timer_eff;
      end
   end

   // Next state: ramp flag and level move only in auto mode; the timer always ticks.
   always_comb begin
      nxt.mode = mode_new;
      if (mode_new == MODE_AUTO) begin
         nxt.ramp_timer   = timer_eff;
         nxt.ramp_started = 1'b1;
         nxt.ramp_value   = ramp_new;
      end else begin
         nxt.ramp_timer   = timer_adv;
         nxt.ramp_started = cur.ramp_started;
         nxt.ramp_value   = cur.ramp_value;
      end
   end

   // Select sources, mirror throttle on reverse, and mix half the steer offset.
   always_comb begin
      if (mode_new == MODE_AUTO) begin
         sv      = cfg.steer_center;
         thr_sel = ramp_new;
      end else begin
         sv      = item.steer_channel;
         thr_sel = item.throttle_channel;
      end
      thr = rev ? ({cfg.throttle_center[14:0], 1'b0} - thr_sel) : thr_sel;

      steer_high = sv >= cfg.steer_center;
      half       = steer_high ? ((sv - cfg.steer_center) >> 1)
                              : ((cfg.steer_center - sv) >> 1);
      sum_plus   = thr + half;
      sum_minus  = thr - half;
      left_raw   = steer_high ? sum_minus[15:2] : sum_plus[15:2];
      right_raw  = steer_high ? sum_plus[15:2] : sum_minus[15:2];

      result.left_drive     = (left_raw > cfg.motor_limit) ? cfg.motor_limit : left_raw;
      result.right_drive    = (right_raw > cfg.motor_limit) ? cfg.motor_limit : right_raw;
      result.drive_mode     = mode_new;
      result.reverse_active = rev;
   end

endmodule

// ===== rtl/core/differential_drive_mixer_top.sv =====
// Stages: input register, mixing logic, result register.
// Throughput: one transaction per cycle while the result side does not stall.
// The input side keeps accepting while a result waits, until the input register is full.
// Reset is synchronous and active high: it empties both stages, sets manual mode,
// clears the ramp timer and start flag, and restores the config and ramp level reset values.
// Top level of the differential drive mixer; depends on ddm_pkg and ddm_core.
module differential_drive_mixer_top
   import ddm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_data_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   state_type state_calc;
   rsp_type   result;
   logic      rsp_advance;
   logic      s1_advance;
   logic      req_accept;

   // Handshake: the result register frees when empty or being taken.
   assign rsp_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = s1_valid_ff && rsp_advance;
   assign req_stall   = s1_valid_ff && !rsp_advance;
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   ddm_core u_core (
      .item   (s1_data_ff),
      .cur    (state_ff),
      .cfg    (cfg_ff),
      .nxt    (state_calc),
      .result (result)
   );

   // Stage valid bits.
   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Configuration writes; a throttle center write reloads the ramp before it starts.
   always_comb begin
      cfg_in   = cfg_ff;
      state_in = s1_advance ? state_calc : state_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_STEER_CENTER:      cfg_in.steer_center      = csr_wdata;
            CSR_THROTTLE_CENTER: begin
               cfg_in.throttle_center = csr_wdata;
               if (!state_ff.ramp_started) begin
                  state_in.ramp_value = csr_wdata;
               end
            end
            CSR_REVERSE_THRESHOLD: cfg_in.reverse_threshold = csr_wdata;
            CSR_MOTOR_LIMIT:       cfg_in.motor_limit       = csr_wdata[13:0];
            CSR_RAMP_HOLD_END:     cfg_in.ramp_hold_end     = csr_wdata;
            CSR_RAMP_RISE_END:     cfg_in.ramp_rise_end     = csr_wdata;
            default: ;
         endcase
      end
   end

   // Control, configuration and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         cfg_ff.steer_center      <= STEER_CENTER_RST;
         cfg_ff.throttle_center   <= THROTTLE_CENTER_RST;
         cfg_ff.reverse_threshold <= REVERSE_THRESHOLD_RST;
         cfg_ff.motor_limit       <= MOTOR_LIMIT_RST;
         cfg_ff.ramp_hold_end     <= RAMP_HOLD_END_RST;
         cfg_ff.ramp_rise_end     <= RAMP_RISE_END_RST;
         state_ff.mode            <= MODE_MANUAL;
         state_ff.ramp_timer      <= 16'd0;
         state_ff.ramp_started    <= 1'b0;
         state_ff.ramp_value      <= THROTTLE_CENTER_RST;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_advance) begin
         rsp_data_ff <= result;
      end
   end

`ifndef SYNTHESIS
   // Input is held off only while the input register is occupied.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall raised with empty input register");

   // An item leaving the input register lands in the result register.
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("advanced item did not reach result register");

   // Once started, the ramp never re-arms.
   a_ramp_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.ramp_started |=> state_ff.ramp_started)
      else $error("ramp start flag cleared");

   // A delivered autonomous result implies the ramp has started.
   a_auto_started: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.drive_mode == MODE_AUTO |-> state_ff.ramp_started)
      else $error("autonomous result without ramp start");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for differential_drive_mixer_top: a directed script, then random
// traffic under several register settings and idling patterns, checked by a local predictor.
// Depends on ddm_pkg and the mixer RTL.
module tb;
   import ddm_pkg::*;

   localparam int CYCLE_LIMIT       = 400000;
   localparam int SEGMENTS          = 12;
   localparam int ITEMS_PER_SEGMENT = 92;
   localparam int PRINT_CAP         = 100;

   // One row of the directed script: a transaction or a register write.
   typedef enum logic {
      STEP_ITEM,
      STEP_WRITE
   } step_kind_type;

   typedef struct {
      step_kind_type kind;
      req_type       stim;
      logic          typed;
      rsp_type       want;
      csr_index_type reg_idx;
      logic [15:0]   reg_value;
   } script_step_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the registers and of the mixer state.
   cfg_type   mixer_cfg;
   state_type mixer_state;
   rsp_type   expected_drives[$];

   int mismatch_count     = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   always #10 clock = ~clock;

   differential_drive_mixer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // Computes the drive result of one transaction and advances the predictor state.
   task automatic mix_predict(input req_type item, output rsp_type res);
      logic [15:0] steer_eff;
      logic [15:0] thr;
      logic [15:0] half;
      logic [15:0] left;
      logic [15:0] right;
      logic [15:0] twice_center;
      logic        rev;
      twice_center = {mixer_cfg.throttle_center[14:0], 1'b0};
      if (item.ms_tick) begin
         mixer_state.ramp_timer = mixer_state.ramp_timer + 16'd1;
      end
      rev = item.reverse_sensor > mixer_cfg.reverse_threshold;

      // Values in the gaps between thresholds keep the previous mode.
      if (item.mode_channel < MANUAL_BELOW) begin
         mixer_state.mode = MODE_MANUAL;
      end else if (item.mode_channel > ASSIST_ABOVE && item.mode_channel < ASSIST_BELOW) begin
         mixer_state.mode = MODE_ASSISTED;
      end else if (item.mode_channel > AUTO_ABOVE) begin
         mixer_state.mode = MODE_AUTO;
      end

      // Autonomous mode runs the one-shot throttle ramp with steering centered.
      if (mixer_state.mode == MODE_AUTO) begin
         steer_eff = mixer_cfg.steer_center;
         if (!mixer_state.ramp_started) begin
            mixer_state.ramp_timer   = 16'd0;
            mixer_state.ramp_started = 1'b1;
         end
         if (mixer_state.ramp_timer >= mixer_cfg.ramp_hold_end) begin
            if (mixer_state.ramp_value <= mixer_cfg.throttle_center) begin
               mixer_state.ramp_value = mixer_cfg.throttle_center;
            end else begin
               mixer_state.ramp_value = twice_center - mixer_state.ramp_timer;
            end
         end else if (mixer_state.ramp_timer <= mixer_cfg.ramp_rise_end) begin
            mixer_state.ramp_value = mixer_cfg.throttle_center + mixer_state.ramp_timer;
         end
         thr = mixer_state.ramp_value;
      end else begin
         steer_eff = item.steer_channel;
         thr       = item.throttle_channel;
      end

      // Mirror the throttle about its center when reversing.
      if (rev) begin
         thr = twice_center - thr;
      end

      // Mix half the steering offset into both sides, all in 16-bit wrap.
      if (steer_eff >= mixer_cfg.steer_center) begin
         half  = (steer_eff - mixer_cfg.steer_center) >> 1;
         left  = (thr - half) >> 2;
         right = (thr + half) >> 2;
      end else begin
         half  = (mixer_cfg.steer_center - steer_eff) >> 1;
         left  = (thr + half) >> 2;
         right = (thr - half) >> 2;
      end

      res.left_drive     = (left > {2'b00, mixer_cfg.motor_limit}) ? mixer_cfg.motor_limit
                                                                   : left[13:0];
      res.right_drive    = (right > {2'b00, mixer_cfg.motor_limit}) ? mixer_cfg.motor_limit
                                                                    : right[13:0];
      res.drive_mode     = mixer_state.mode;
      res.reverse_active = rev;
   endtask

   // Presents one transaction, waits for its acceptance and records the expected result.
   task automatic send_item(input req_type item, input logic typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      mix_predict(item, predicted);
      expected_drives.push_back(typed ? want : predicted);
   endtask

   // Writes one register once the mixer has drained, and mirrors it in the predictor.
   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEER_CENTER: begin
            mixer_cfg.steer_center = value;
         end
         CSR_THROTTLE_CENTER: begin
            mixer_cfg.throttle_center = value;
            // The ramp level follows the center only until the ramp has started.
            if (!mixer_state.ramp_started) begin
               mixer_state.ramp_value = value;
            end
         end
         CSR_REVERSE_THRESHOLD: begin
            mixer_cfg.reverse_threshold = value;
         end
         CSR_MOTOR_LIMIT: begin
            mixer_cfg.motor_limit = value[13:0];
         end
         CSR_RAMP_HOLD_END: begin
            mixer_cfg.ramp_hold_end = value;
         end
         CSR_RAMP_RISE_END: begin
            mixer_cfg.ramp_rise_end = value;
         end
         default: begin
         end
      endcase
   endtask

   function automatic script_step_type item_step(input logic [15:0] steer,
                                                 input logic [15:0] thr,
                                                 input logic [15:0] mode,
                                                 input logic [15:0] sens,
                                                 input logic tick);
      script_step_type s;
      s.kind      = STEP_ITEM;
      s.stim      = {steer, thr, mode, sens, tick};
      s.typed     = 1'b0;
      s.want      = '0;
      s.reg_idx   = CSR_STEER_CENTER;
      s.reg_value = '0;
      return s;
   endfunction

   function automatic script_step_type known_step(input logic [15:0] steer,
                                                  input logic [15:0] thr,
                                                  input logic [15:0] mode,
                                                  input logic [15:0] sens,
                                                  input logic tick, input logic [13:0] left,
                                                  input logic [13:0] right, input mode_type m,
                                                  input logic rev);
      script_step_type s;
      s       = item_step(steer, thr, mode, sens, tick);
      s.typed = 1'b1;
      s.want  = {left, right, m, rev};
      return s;
   endfunction

   function automatic script_step_type write_step(input csr_index_type idx,
                                                  input logic [15:0] value);
      script_step_type s;
      s           = item_step(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      s.kind      = STEP_WRITE;
      s.reg_idx   = idx;
      s.reg_value = value;
      return s;
   endfunction

   // Result side: random stall, and each accepted transaction checked against the oldest
   // expectation.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= PRINT_CAP) begin
               $display("%0t: expected no result, actual %0d/%0d/%0d/%0d",
                        $time, rsp_data.left_drive, rsp_data.right_drive,
                        rsp_data.drive_mode, rsp_data.reverse_active);
            end
         end else begin
            want = expected_drives.pop_front();
            if (rsp_data.left_drive !== want.left_drive ||
                rsp_data.right_drive !== want.right_drive ||
                rsp_data.drive_mode !== want.drive_mode ||
                rsp_data.reverse_active !== want.reverse_active) begin
               mismatch_count++;
               if (mismatch_count <= PRINT_CAP) begin
                  $display("%0t: expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
                           $time, want.left_drive, want.right_drive, want.drive_mode,
                           want.reverse_active, rsp_data.left_drive, rsp_data.right_drive,
                           rsp_data.drive_mode, rsp_data.reverse_active);
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("differential_drive_mixer_top: mismatch");
         $finish;
      end
   end

   initial begin
      script_step_type directed_script[$];
      req_type         item;
      logic [15:0]     cfg_values[6];
      logic [15:0]     offset;
      logic            hi;
      int              band;

      mixer_cfg   = '{STEER_CENTER_RST, THROTTLE_CENTER_RST, REVERSE_THRESHOLD_RST,
                      MOTOR_LIMIT_RST, RAMP_HOLD_END_RST, RAMP_RISE_END_RST};
      mixer_state = '{MODE_MANUAL, 16'd0, 1'b0, THROTTLE_CENTER_RST};
      band        = 0;

      // Directed script at reset settings: extremes, reverse threshold edge, mode gaps.
      directed_script.push_back(known_step(6000, 6000, 0, 0, 0, 1500, 1500, MODE_MANUAL, 0));
      directed_script.push_back(known_step(6000, 65535, 0, 0, 1, 2016, 2016, MODE_MANUAL, 0));
      directed_script.push_back(known_step(6000, 0, 4999, 900, 0, 0, 0, MODE_MANUAL, 0));
      directed_script.push_back(known_step(6000, 6000, 4999, 901, 0, 1500, 1500, MODE_MANUAL, 1));
      directed_script.push_back(known_step(6000, 0, 0, 65535, 1, 2016, 2016, MODE_MANUAL, 1));
      directed_script.push_back(known_step(65535, 6000, 0, 0, 0, 2016, 2016, MODE_MANUAL, 0));
      directed_script.push_back(known_step(0, 6000, 0, 0, 0, 2016, 750, MODE_MANUAL, 0));
      directed_script.push_back(item_step(6002, 6000, 0, 0, 0));
      directed_script.push_back(item_step(5998, 6000, 0, 0, 1));
      directed_script.push_back(known_step(6000, 6000, 5501, 0, 0, 1500, 1500, MODE_ASSISTED, 0));
      directed_script.push_back(known_step(6000, 6000, 5000, 0, 0, 1500, 1500, MODE_ASSISTED, 0));
      directed_script.push_back(known_step(6000, 6000, 5500, 0, 0, 1500, 1500, MODE_ASSISTED, 0));
      directed_script.push_back(known_step(6000, 6000, 6499, 0, 0, 1500, 1500, MODE_ASSISTED, 0));
      directed_script.push_back(known_step(6000, 6000, 6500, 0, 0, 1500, 1500, MODE_ASSISTED, 0));
      directed_script.push_back(known_step(6000, 6000, 7000, 0, 0, 1500, 1500, MODE_ASSISTED, 0));
      directed_script.push_back(known_step(6000, 6000, 5200, 0, 1, 1500, 1500, MODE_ASSISTED, 0));
      directed_script.push_back(known_step(6000, 4000, 0, 0, 0, 1000, 1000, MODE_MANUAL, 0));
      directed_script.push_back(known_step(6000, 4000, 6800, 0, 0, 1000, 1000, MODE_MANUAL, 0));
      // A center write before the ramp starts reloads the ramp level; one after it does not.
      directed_script.push_back(write_step(CSR_RAMP_HOLD_END, 0));
      directed_script.push_back(write_step(CSR_THROTTLE_CENTER, 5000));
      directed_script.push_back(item_step(6000, 6000, 7001, 0, 0));
      directed_script.push_back(write_step(CSR_THROTTLE_CENTER, 5200));
      directed_script.push_back(write_step(CSR_RAMP_HOLD_END, 4000));
      directed_script.push_back(item_step(0, 65535, 65535, 65535, 1));
      directed_script.push_back(item_step(65535, 0, 7001, 0, 1));
      directed_script.push_back(item_step(6000, 6000, 6800, 900, 1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_script[i]) begin
         if (directed_script[i].kind == STEP_WRITE) begin
            write_register(directed_script[i].reg_idx, directed_script[i].reg_value);
         end else begin
            send_item(directed_script[i].stim, directed_script[i].typed, directed_script[i].want);
         end
      end

      // Random segments: each rewrites every register, then runs one idling pattern.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg % 3 == 1) begin
            // Extreme settings: all low, all high, then a random mix of both.
            for (int r = 0; r < 6; r++) begin
               hi = (seg == 1) ? 1'b0 : (seg == 4) ? 1'b1 : 1'($urandom_range(1));
               cfg_values[r] = hi ? 16'hFFFF : 16'h0000;
            end
            cfg_values[CSR_MOTOR_LIMIT] = cfg_values[CSR_MOTOR_LIMIT] & 16'h3FFF;
         end else begin
            // Typical settings, with the ramp breakpoints just ahead of the running timer.
            cfg_values[CSR_STEER_CENTER]      = 16'($urandom_range(7000, 5000));
            cfg_values[CSR_THROTTLE_CENTER]   = 16'($urandom_range(7000, 5000));
            cfg_values[CSR_REVERSE_THRESHOLD] = 16'($urandom_range(2000));
            cfg_values[CSR_MOTOR_LIMIT]       = 16'($urandom_range(16383, 1000));
            cfg_values[CSR_RAMP_RISE_END]     = mixer_state.ramp_timer + 16'($urandom_range(30));
            cfg_values[CSR_RAMP_HOLD_END]     = cfg_values[CSR_RAMP_RISE_END]
                                                + 16'($urandom_range(60, 1));
         end
         for (int r = 0; r < 6; r++) begin
            write_register(csr_index_type'(r), cfg_values[r]);
         end

         case (seg / 3)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 75;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 75;
            end
            default: begin
               sender_idle_pct    = 18;
               receiver_stall_pct = 18;
            end
         endcase

         for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
            // The mode switch mostly stays in one band for a stretch, as a real stick does.
            if ($urandom_range(11) == 0) begin
               band = int'($urandom_range(3));
            end
            if ($urandom_range(9) == 0) begin
               item.steer_channel    = 16'($urandom_range(65535));
               item.throttle_channel = 16'($urandom_range(65535));
               item.mode_channel     = 16'($urandom_range(65535));
               item.reverse_sensor   = 16'($urandom_range(65535));
            end else begin
               case (band)
                  0: item.mode_channel = 16'($urandom_range(4999));
                  1: item.mode_channel = 16'($urandom_range(6499, 5501));
                  2: item.mode_channel = 16'($urandom_range(65535, 7001));
                  default: item.mode_channel = $urandom_range(1)
                                               ? 16'($urandom_range(5500, 5000))
                                               : 16'($urandom_range(7000, 6500));
               endcase
               offset                = 16'($urandom_range(8000));
               item.steer_channel    = mixer_cfg.steer_center + offset - 16'd4000;
               offset                = 16'($urandom_range(8000));
               item.throttle_channel = mixer_cfg.throttle_center + offset - 16'd4000;
               offset                = 16'($urandom_range(40));
               item.reverse_sensor   = $urandom_range(1) ? mixer_cfg.reverse_threshold
                                                           + offset - 16'd20
                                                         : 16'($urandom_range(65535));
            end
            item.ms_tick = 1'($urandom_range(1));
            send_item(item, 1'b0, '0);
         end
      end

      // Drain and let the pipeline settle before the verdict.
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("differential_drive_mixer_top: match");
      end else begin
         $display("differential_drive_mixer_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ddm_pkg.sv
rtl/core/ddm_core.sv
rtl/core/differential_drive_mixer_top.sv
dv/tb.sv
